// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/buddy_pkg.sv =====
package buddy_pkg;

   localparam int TOTAL_UNITS_DEF = 1024;
   // order values up to 31
   localparam int ORD_W = 5;
   // wide enough for any unit address plus carry
   localparam int WIDE_W = 17;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   typedef struct packed {
      logic        command;
      logic [10:0] request_size;
      logic [9:0]  free_start;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] block_start;
      logic [3:0] block_order;
   } rsp_type;

   // one entry per unit
   typedef struct packed {
      logic             start;
      logic [ORD_W-1:0] order;
      logic             used;
   } word_type;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_WAIT  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_SPLIT = 7'b0010000,
      S_FFIN  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

endpackage

// ===== sv/buddy_allocator.sv =====
// channel  | ports                         | payload
// request  | req_valid  req_stall req_data | command, request_size, free_start
// response | rsp_valid  rsp_stall rsp_data | status, block_start, block_order
//
// one request at a time through one unit-table read port (address, registered read, evaluate)
// allocate: scan every block for the smallest fit, split it down to size, mark it used, answer
// free: check the named block, merge free buddies (at most top order of them), mark free, answer
// a size too large or a start beyond the memory goes to the answer without a table read
// after reset a clearing pass writes every table entry before the first request
// a response held by rsp_stall does not block the next request being taken
`include "assert_macros.svh"

module buddy_allocator #(
   parameter int TOTAL_UNITS = buddy_pkg::TOTAL_UNITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  buddy_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output buddy_pkg::rsp_type rsp_data
);

   localparam int TOP_ORDER = $clog2(TOTAL_UNITS + 1) - 1;
   localparam int MEM_UNITS = 1 << TOP_ORDER;
   localparam int AW        = TOP_ORDER;
   localparam int OW        = buddy_pkg::ORD_W;
   localparam int WW        = buddy_pkg::WIDE_W;

   buddy_pkg::word_type mem [MEM_UNITS];
   buddy_pkg::word_type rdata_ff;

   buddy_pkg::state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [OW-1:0] need_ff, need_in;
   logic          op_ff, op_in;
   logic          first_ff, first_in;
   logic          found_ff, found_in;
   buddy_pkg::rsp_type res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   buddy_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                we;
   logic [AW-1:0]       waddr;
   buddy_pkg::word_type wdata;

   logic          accept;
   logic [OW-1:0] need_c;
   logic [WW-1:0] fs_wide;
   logic [AW:0]   next_u;
   logic          take_c;
   logic [OW-1:0] best_ord_c;
   logic [AW-1:0] best_c;
   logic          match_c;
   logic [AW-1:0] lo_c, hi_c;
   logic [OW-1:0] ord_up;

   // unit table, one write and one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   assign req_stall = (state_ff != buddy_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // rounded-up log2 of the request, zero counts as one
   always_comb begin
      need_c = OW'(0);
      for (int n = 11; n >= 0; n--) begin
         if ({1'b0, req_data.request_size} <= (12'(1) << n)) begin
            need_c = OW'(n);
         end
      end
   end

   assign fs_wide = WW'(req_data.free_start);

   // scan helpers
   assign next_u  = {1'b0, addr_ff} + ((AW + 1)'(1) << rdata_ff.order);
   assign take_c  = !rdata_ff.used && (rdata_ff.order >= need_ff)
                    && (!found_ff || (rdata_ff.order < ord_ff));
   assign best_ord_c = take_c ? rdata_ff.order : ord_ff;
   assign best_c     = take_c ? addr_ff : cur_ff;

   // merge helpers
   assign match_c = rdata_ff.start && (rdata_ff.order == ord_ff) && !rdata_ff.used;
   assign lo_c    = (addr_ff < cur_ff) ? addr_ff : cur_ff;
   assign hi_c    = (addr_ff < cur_ff) ? cur_ff : addr_ff;
   assign ord_up  = ord_ff + OW'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cur_in       = cur_ff;
      ord_in       = ord_ff;
      need_in      = need_ff;
      op_in        = op_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      we           = 1'b0;
      waddr        = addr_ff;
      wdata        = '0;

      unique case (state_ff)
         buddy_pkg::S_CLEAR: begin
            we    = 1'b1;
            wdata = '0;
            if (addr_ff == '0) begin
               wdata.start = 1'b1;
               wdata.order = OW'(TOP_ORDER);
            end
            addr_in = addr_ff + AW'(1);
            if (addr_ff == {AW{1'b1}}) begin
               addr_in  = '0;
               state_in = buddy_pkg::S_IDLE;
            end
         end
         buddy_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_data.command;
               first_in = 1'b1;
               found_in = 1'b0;
               need_in  = need_c;
               if (req_data.command == buddy_pkg::CMD_ALLOC) begin
                  if (need_c > OW'(TOP_ORDER)) begin
                     res_in   = '{buddy_pkg::ST_NOFIT, 10'd0, 4'd0};
                     state_in = buddy_pkg::S_OUT;
                  end else begin
                     addr_in  = '0;
                     state_in = buddy_pkg::S_WAIT;
                  end
               end else begin
                  if (fs_wide >= WW'(MEM_UNITS)) begin
                     res_in   = '{buddy_pkg::ST_BADFREE, req_data.free_start, 4'd0};
                     state_in = buddy_pkg::S_OUT;
                  end else begin
                     addr_in  = fs_wide[AW-1:0];
                     state_in = buddy_pkg::S_WAIT;
                  end
               end
            end
         end
         buddy_pkg::S_WAIT: begin
            state_in = buddy_pkg::S_EVAL;
         end
         buddy_pkg::S_EVAL: begin
            if (op_ff == buddy_pkg::CMD_ALLOC) begin
               // walk all blocks, keep the smallest free one that fits
               found_in = found_ff || take_c;
               ord_in   = best_ord_c;
               cur_in   = best_c;
               if (next_u[AW]) begin
                  if (found_ff || take_c) begin
                     state_in = buddy_pkg::S_SPLIT;
                  end else begin
                     res_in   = '{buddy_pkg::ST_NOFIT, 10'd0, 4'd0};
                     state_in = buddy_pkg::S_OUT;
                  end
               end else begin
                  addr_in  = next_u[AW-1:0];
                  state_in = buddy_pkg::S_WAIT;
               end
            end else if (first_ff) begin
               // check the named block
               first_in = 1'b0;
               if (!rdata_ff.start || !rdata_ff.used) begin
                  res_in   = '{buddy_pkg::ST_BADFREE, 10'(WW'(addr_ff)), 4'd0};
                  state_in = buddy_pkg::S_OUT;
               end else begin
                  cur_in = addr_ff;
                  ord_in = rdata_ff.order;
                  if (rdata_ff.order < OW'(TOP_ORDER)) begin
                     addr_in  = addr_ff ^ (AW'(1) << rdata_ff.order);
                     state_in = buddy_pkg::S_WAIT;
                  end else begin
                     state_in = buddy_pkg::S_FFIN;
                  end
               end
            end else begin
               // merge with a free buddy of the same order
               if (match_c) begin
                  we     = 1'b1;
                  waddr  = hi_c;
                  wdata  = '0;
                  cur_in = lo_c;
                  ord_in = ord_up;
                  if (ord_up < OW'(TOP_ORDER)) begin
                     addr_in  = lo_c ^ (AW'(1) << ord_up);
                     state_in = buddy_pkg::S_WAIT;
                  end else begin
                     state_in = buddy_pkg::S_FFIN;
                  end
               end else begin
                  state_in = buddy_pkg::S_FFIN;
               end
            end
         end
         buddy_pkg::S_SPLIT: begin
            we = 1'b1;
            if (ord_ff > need_ff) begin
               // upper half becomes a free block
               ord_in      = ord_ff - OW'(1);
               waddr       = cur_ff + (AW'(1) << (ord_ff - OW'(1)));
               wdata.start = 1'b1;
               wdata.order = ord_ff - OW'(1);
               wdata.used  = 1'b0;
            end else begin
               waddr       = cur_ff;
               wdata.start = 1'b1;
               wdata.order = ord_ff;
               wdata.used  = 1'b1;
               res_in      = '{buddy_pkg::ST_OK, 10'(WW'(cur_ff)), 4'(ord_ff)};
               state_in    = buddy_pkg::S_OUT;
            end
         end
         buddy_pkg::S_FFIN: begin
            we          = 1'b1;
            waddr       = cur_ff;
            wdata.start = 1'b1;
            wdata.order = ord_ff;
            wdata.used  = 1'b0;
            res_in      = '{buddy_pkg::ST_OK, 10'(WW'(cur_ff)), 4'(ord_ff)};
            state_in    = buddy_pkg::S_OUT;
         end
         buddy_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = buddy_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = buddy_pkg::S_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= buddy_pkg::S_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      ord_ff      <= ord_in;
      need_ff     <= need_in;
      op_ff       <= op_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `ASSERT_NEXT(busy_after_request, accept, state_ff != buddy_pkg::S_IDLE, "request not started")
   `ASSERT_IMPL(ok_order_range, rsp_valid_ff && rsp_data_ff.status == buddy_pkg::ST_OK, rsp_data_ff.block_order <= 4'(TOP_ORDER), "order above top")
   `ASSERT_IMPL(no_write_idle, state_ff == buddy_pkg::S_IDLE || state_ff == buddy_pkg::S_OUT, !we, "table written while idle")

endmodule
